// File: hw/rtl/linear_probe_hash_table_unit_assert.svh
// Assertion macros for the hash table checker
`ifndef LINEAR_PROBE_HASH_TABLE_UNIT_ASSERT_SVH
`define LINEAR_PROBE_HASH_TABLE_UNIT_ASSERT_SVH

// Implication checked at each rising edge, quiet during reset
`define LPHT_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, quiet during reset
`define LPHT_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hw/rtl/lpht_pkg.sv
// Types, codes and constants for the linear probing hash table
`timescale 1ns / 1ps
package lpht_pkg;

    localparam int TABLE_DEPTH_DEF = 256;
    localparam int KEY_BITS_DEF    = 48;
    localparam int MAC_BITS        = 48;
    localparam int CFG_W           = 9;
    localparam int CFG_IDX_W       = 1;
    localparam int POS_W           = 8;
    localparam int DIV_STEP        = 4;
    localparam int DIV_CYCLES      = MAC_BITS / DIV_STEP;
    localparam int QUEUE_DEPTH     = 2;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_HASH_MODULUS = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_TABLE_USED   = 1'b1;

    // Commands
    localparam logic [1:0] CMD_INSERT = 2'd0;
    localparam logic [1:0] CMD_DELETE = 2'd1;
    localparam logic [1:0] CMD_SEARCH = 2'd2;
    localparam logic [1:0] CMD_READ   = 2'd3;

    // Result status
    localparam logic [2:0] RES_INSERTED  = 3'd0;
    localparam logic [2:0] RES_FULL      = 3'd1;
    localparam logic [2:0] RES_DELETED   = 3'd2;
    localparam logic [2:0] RES_NOT_FOUND = 3'd3;
    localparam logic [2:0] RES_FOUND     = 3'd4;
    localparam logic [2:0] RES_READ      = 3'd5;

    // Slot state
    localparam logic [1:0] SLOT_EMPTY   = 2'd0;
    localparam logic [1:0] SLOT_USED    = 2'd1;
    localparam logic [1:0] SLOT_DELETED = 2'd2;

    typedef struct packed {
        logic [1:0]          cmd;
        logic [MAC_BITS-1:0] mac_key;
        logic [POS_W-1:0]    slot_index;
    } req_t;

    typedef struct packed {
        logic [2:0]          status;
        logic [POS_W-1:0]    position;
        logic [MAC_BITS-1:0] slot_key;
        logic [1:0]          slot_state;
    } rsp_t;

    // Classified operation handed from front to back
    typedef struct packed {
        logic [1:0]          cmd;
        logic [MAC_BITS-1:0] key;
        logic [POS_W-1:0]    slot_index;
        logic [CFG_W-1:0]    home;
    } op_t;

endpackage

// File: hw/rtl/lpht_chan_if.sv
// Valid/ready channel carrying one word
`timescale 1ns / 1ps
interface lpht_chan_if #(parameter type word_t = logic);
    logic  valid;
    logic  ready;
    word_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// File: hw/rtl/linear_probe_hash_table_unit.sv
// Top level of the linear probing hash table of MAC keys
//
//  channel | dir | handshake      | word
//  req     | in  | valid / ready  | cmd, mac_key, slot_index
//  rsp     | out | valid / ready  | status, position, slot_key, slot_state
//  cfg     | in  | cfg_we         | cfg_index, cfg_wdata
//
// Home slot: computed by the front divider (4 key bits per cycle); a read skips it.
// Probing: each slot visited takes a memory read, then a check, up to table_used slots.
// The front divides the next word while the back probes the current one.
// After reset the back clears the status of every slot; req.ready stays low meanwhile.
// A held result on rsp stalls the back; the queue then stalls the front.
`timescale 1ns / 1ps
module linear_probe_hash_table_unit
    import lpht_pkg::*;
#(
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEF,
    parameter int KEY_BITS    = KEY_BITS_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    lpht_chan_if.sink            req,
    lpht_chan_if.source          rsp,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_wdata
);

    logic [CFG_W-1:0] hash_modulus_reg;
    logic [CFG_W-1:0] table_used_reg;
    logic [CFG_W-1:0] used_eff;
    logic [CFG_W-1:0] mod_eff;
    op_t              push_op, pop_op;
    logic             push_valid, push_ready;
    logic             pop_valid, pop_ready;
    logic             clearing;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hash_modulus_reg <= CFG_W'(256);
            table_used_reg   <= CFG_W'(256);
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_HASH_MODULUS: hash_modulus_reg <= cfg_wdata;
                REG_TABLE_USED:   table_used_reg   <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // Clamp probe limit and modulus
    always_comb
    begin
        if (table_used_reg == '0)
            used_eff = CFG_W'(1);
        else if (32'(table_used_reg) > TABLE_DEPTH)
            used_eff = CFG_W'(TABLE_DEPTH);
        else
            used_eff = table_used_reg;

        if (hash_modulus_reg == '0)
            mod_eff = CFG_W'(1);
        else if (hash_modulus_reg > used_eff)
            mod_eff = used_eff;
        else
            mod_eff = hash_modulus_reg;
    end

    lpht_front #(.KEY_BITS(KEY_BITS)) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .enable     (!clearing),
        .mod_eff    (mod_eff),
        .req        (req),
        .push_op    (push_op),
        .push_valid (push_valid),
        .push_ready (push_ready)
    );

    lpht_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_op    (push_op),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .pop_op     (pop_op),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready)
    );

    lpht_back #(.TABLE_DEPTH(TABLE_DEPTH), .KEY_BITS(KEY_BITS)) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .used_eff  (used_eff),
        .mod_eff   (mod_eff),
        .pop_op    (pop_op),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .clearing  (clearing),
        .rsp       (rsp)
    );

endmodule

// File: hw/rtl/lpht_front.sv
// Front end: accepts words, masks the key and computes the home slot (not for reads)
`timescale 1ns / 1ps
module lpht_front
    import lpht_pkg::*;
#(
    parameter int KEY_BITS = KEY_BITS_DEF
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             enable,
    input  logic [CFG_W-1:0] mod_eff,
    lpht_chan_if.sink        req,
    output op_t              push_op,
    output logic             push_valid,
    input  logic             push_ready
);

    localparam logic [MAC_BITS-1:0] KEY_MASK = (KEY_BITS >= MAC_BITS) ? '1 :
        MAC_BITS'((64'd1 << KEY_BITS) - 64'd1);
    localparam int CNT_W = $clog2(DIV_CYCLES);

    typedef enum logic [2:0] {
        F_IDLE = 3'b001,
        F_DIV  = 3'b010,
        F_PUSH = 3'b100
    } fstate_t;

    fstate_t             state_reg, state_next;
    op_t                 op_reg, op_next;
    logic [CFG_W-1:0]    rem_reg, rem_next;
    logic [MAC_BITS-1:0] dvd_reg, dvd_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic [CFG_W-1:0]    rem_step;
    logic [MAC_BITS-1:0] dvd_step;

    // Restoring remainder, DIV_STEP dividend bits per cycle
    always_comb
    begin
        logic [CFG_W:0]      t;
        logic [CFG_W-1:0]    r;
        logic [MAC_BITS-1:0] d;
        r = rem_reg;
        d = dvd_reg;
        for (int i = 0; i < DIV_STEP; i++)
        begin
            t = {r, d[MAC_BITS-1]};
            d = {d[MAC_BITS-2:0], 1'b0};
            if (t >= {1'b0, mod_eff})
                r = CFG_W'(t - {1'b0, mod_eff});
            else
                r = CFG_W'(t);
        end
        rem_step = r;
        dvd_step = d;
    end

    assign req.ready  = (state_reg == F_IDLE) && enable;
    assign push_valid = (state_reg == F_PUSH);
    assign push_op    = op_reg;

    // Sequencer
    always_comb
    begin
        state_next = state_reg;
        op_next    = op_reg;
        rem_next   = rem_reg;
        dvd_next   = dvd_reg;
        cnt_next   = cnt_reg;
        case (state_reg)
            F_IDLE:
            begin
                if (req.valid && enable)
                begin
                    op_next.cmd        = req.data.cmd;
                    op_next.key        = req.data.mac_key & KEY_MASK;
                    op_next.slot_index = req.data.slot_index;
                    op_next.home       = '0;
                    rem_next           = '0;
                    dvd_next           = req.data.mac_key & KEY_MASK;
                    cnt_next           = '0;
                    state_next         = (req.data.cmd == CMD_READ) ? F_PUSH : F_DIV;
                end
            end
            F_DIV:
            begin
                rem_next = rem_step;
                dvd_next = dvd_step;
                cnt_next = CNT_W'(cnt_reg + 1'b1);
                if (cnt_reg == CNT_W'(DIV_CYCLES - 1))
                begin
                    op_next.home = rem_step;
                    state_next   = F_PUSH;
                end
            end
            F_PUSH:
            begin
                if (push_ready)
                    state_next = F_IDLE;
            end
            default:
                state_next = F_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= F_IDLE;
        else
            state_reg <= state_next;
    end

    always_ff @(posedge clk)
    begin
        op_reg  <= op_next;
        rem_reg <= rem_next;
        dvd_reg <= dvd_next;
        cnt_reg <= cnt_next;
    end

endmodule

// File: hw/rtl/lpht_queue.sv
// Short queue of classified operations between front and back
`timescale 1ns / 1ps
module lpht_queue
    import lpht_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  op_t  push_op,
    input  logic push_valid,
    output logic push_ready,
    output op_t  pop_op,
    output logic pop_valid,
    input  logic pop_ready
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    op_t              entry_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_reg, wr_next;
    logic [PTR_W-1:0] rd_reg, rd_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             do_push, do_pop;

    assign push_ready = (cnt_reg != CNT_W'(QUEUE_DEPTH));
    assign pop_valid  = (cnt_reg != '0);
    assign pop_op     = entry_reg[rd_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    // Pointer and fill update
    always_comb
    begin
        wr_next  = wr_reg;
        rd_next  = rd_reg;
        cnt_next = cnt_reg;
        if (do_push)
            wr_next = (wr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : PTR_W'(wr_reg + 1'b1);
        if (do_pop)
            rd_next = (rd_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : PTR_W'(rd_reg + 1'b1);
        if (do_push && !do_pop)
            cnt_next = CNT_W'(cnt_reg + 1'b1);
        else if (do_pop && !do_push)
            cnt_next = CNT_W'(cnt_reg - 1'b1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            entry_reg[wr_reg] <= push_op;
    end

endmodule

// File: hw/rtl/lpht_back.sv
// Back end: slot memories, probe sequencer and result register
`timescale 1ns / 1ps
module lpht_back
    import lpht_pkg::*;
#(
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEF,
    parameter int KEY_BITS    = KEY_BITS_DEF
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic [CFG_W-1:0] used_eff,
    input  logic [CFG_W-1:0] mod_eff,
    input  op_t              pop_op,
    input  logic             pop_valid,
    output logic             pop_ready,
    output logic             clearing,
    lpht_chan_if.source      rsp
);

    localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

    typedef enum logic [3:0] {
        B_CLEAR = 4'b0001,
        B_IDLE  = 4'b0010,
        B_READ  = 4'b0100,
        B_CHECK = 4'b1000
    } bstate_t;

    bstate_t             state_reg, state_next;
    op_t                 op_reg, op_next;
    logic [CFG_W-1:0]    pos_reg, pos_next;
    logic [CFG_W-1:0]    n_reg, n_next;
    logic [IDX_W-1:0]    clr_reg, clr_next;
    logic                rsp_valid_reg, rsp_valid_next;
    rsp_t                rsp_reg, rsp_next;

    logic [1:0]          status_mem [TABLE_DEPTH];
    logic [KEY_BITS-1:0] key_mem    [TABLE_DEPTH];
    logic [1:0]          st_q;
    logic [KEY_BITS-1:0] key_q;
    logic [IDX_W-1:0]    rd_addr;
    logic                wr_en, key_wr_en;
    logic [IDX_W-1:0]    wr_addr;
    logic [1:0]          wr_st;
    logic                out_free;
    logic [CFG_W:0]      pos_inc;
    logic                oob;
    logic [KEY_BITS-1:0] op_key;
    logic [1:0]          rd_st;

    assign out_free  = !rsp_valid_reg || rsp.ready;
    assign rsp.valid = rsp_valid_reg;
    assign rsp.data  = rsp_reg;
    assign clearing  = (state_reg == B_CLEAR);
    assign pop_ready = (state_reg == B_IDLE);
    assign pos_inc   = {1'b0, pos_reg} + 1'b1;
    assign op_key    = KEY_BITS'(op_reg.key);
    assign rd_addr   = (op_reg.cmd == CMD_READ) ? IDX_W'(op_reg.slot_index) : IDX_W'(pos_reg);
    assign oob       = (32'(op_reg.slot_index) >= TABLE_DEPTH);
    assign rd_st     = oob ? SLOT_EMPTY : st_q;

    // Probe sequencer
    always_comb
    begin
        state_next     = state_reg;
        op_next        = op_reg;
        pos_next       = pos_reg;
        n_next         = n_reg;
        clr_next       = clr_reg;
        rsp_valid_next = rsp_valid_reg && !rsp.ready;
        rsp_next       = rsp_reg;
        wr_en          = 1'b0;
        key_wr_en      = 1'b0;
        wr_addr        = IDX_W'(pos_reg);
        wr_st          = SLOT_EMPTY;
        case (state_reg)
            B_CLEAR:
            begin
                wr_en    = 1'b1;
                wr_addr  = clr_reg;
                clr_next = IDX_W'(clr_reg + 1'b1);
                if (clr_reg == IDX_W'(TABLE_DEPTH - 1))
                    state_next = B_IDLE;
            end
            B_IDLE:
            begin
                if (pop_valid)
                begin
                    op_next    = pop_op;
                    pos_next   = pop_op.home;
                    n_next     = '0;
                    state_next = B_READ;
                end
            end
            B_READ:
                state_next = B_CHECK;
            B_CHECK:
            begin
                // Held result word stays untouched until it leaves
                if (out_free)
                begin
                    rsp_next.status     = RES_NOT_FOUND;
                    rsp_next.position   = '0;
                    rsp_next.slot_key   = '0;
                    rsp_next.slot_state = SLOT_EMPTY;
                end
                if (op_reg.cmd == CMD_READ)
                begin
                    if (out_free)
                    begin
                        rsp_next.status     = RES_READ;
                        rsp_next.position   = op_reg.slot_index;
                        rsp_next.slot_state = rd_st;
                        rsp_next.slot_key   = (rd_st == SLOT_EMPTY) ? '0 : MAC_BITS'(key_q);
                        rsp_valid_next      = 1'b1;
                        state_next          = B_IDLE;
                    end
                end
                else if ((op_reg.cmd == CMD_INSERT && st_q != SLOT_USED) ||
                         (op_reg.cmd != CMD_INSERT && st_q == SLOT_USED && key_q == op_key))
                begin
                    // Hit: commit any slot change with the result
                    if (out_free)
                    begin
                        rsp_next.position = POS_W'(pos_reg);
                        rsp_valid_next    = 1'b1;
                        state_next        = B_IDLE;
                        if (op_reg.cmd == CMD_INSERT)
                        begin
                            rsp_next.status = RES_INSERTED;
                            wr_en           = 1'b1;
                            key_wr_en       = 1'b1;
                            wr_st           = SLOT_USED;
                        end
                        else if (op_reg.cmd == CMD_DELETE)
                        begin
                            rsp_next.status = RES_DELETED;
                            wr_en           = 1'b1;
                            wr_st           = SLOT_DELETED;
                        end
                        else
                            rsp_next.status = RES_FOUND;
                    end
                end
                else if ((op_reg.cmd != CMD_INSERT && st_q == SLOT_EMPTY) ||
                         (CFG_W'(n_reg + 1'b1) == used_eff))
                begin
                    // Chain ended or probe limit reached
                    if (out_free)
                    begin
                        rsp_next.status = (op_reg.cmd == CMD_INSERT) ? RES_FULL : RES_NOT_FOUND;
                        rsp_valid_next  = 1'b1;
                        state_next      = B_IDLE;
                    end
                end
                else
                begin
                    n_next     = CFG_W'(n_reg + 1'b1);
                    pos_next   = (pos_inc == {1'b0, mod_eff}) ? '0 : CFG_W'(pos_inc);
                    state_next = B_READ;
                end
            end
            default:
                state_next = B_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_CLEAR;
            clr_reg       <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg  <= op_next;
        pos_reg <= pos_next;
        n_reg   <= n_next;
        rsp_reg <= rsp_next;
    end

    // Slot memories, registered read
    always_ff @(posedge clk)
    begin
        if (wr_en)
            status_mem[wr_addr] <= wr_st;
        if (key_wr_en)
            key_mem[wr_addr] <= op_key;
        if (state_reg == B_READ)
        begin
            st_q  <= status_mem[rd_addr];
            key_q <= key_mem[rd_addr];
        end
    end

endmodule

// File: hw/rtl/lpht_checker.sv
// Port-level checker for the hash table, bound to the top level
`timescale 1ns / 1ps
`include "linear_probe_hash_table_unit_assert.svh"
module lpht_checker
    import lpht_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    input logic       rsp_valid,
    input logic       rsp_ready,
    input rsp_t       rsp_data
);

    `LPHT_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid, "rsp dropped while stalled")
    `LPHT_ASSERT_NEXT(a_rsp_stable, rsp_valid && !rsp_ready, $stable(rsp_data), "rsp word changed while stalled")
    `LPHT_ASSERT_IMP(a_status_code, rsp_valid, rsp_data.status <= RES_READ, "bad status code")
    `LPHT_ASSERT_IMP(a_slot_fields, rsp_valid && rsp_data.status != RES_READ, rsp_data.slot_key == '0 && rsp_data.slot_state == SLOT_EMPTY, "slot fields set on a non-read result")
    `LPHT_ASSERT_IMP(a_miss_pos, rsp_valid && (rsp_data.status == RES_FULL || rsp_data.status == RES_NOT_FOUND), rsp_data.position == '0, "miss with nonzero position")

endmodule

bind linear_probe_hash_table_unit lpht_checker u_lpht_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .rsp_valid (rsp.valid),
    .rsp_ready (rsp.ready),
    .rsp_data  (rsp.data)
);

// File: tb/tb.sv
// Self-checking testbench for the linear probing hash table of MAC keys
`timescale 1ns / 1ps
module tb;
    import lpht_pkg::*;

    localparam int DEPTH = 256;

    logic clk;
    logic rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_wdata;

    lpht_chan_if #(.word_t(req_t)) req_ch ();
    lpht_chan_if #(.word_t(rsp_t)) rsp_ch ();

    linear_probe_hash_table_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req_ch),
        .rsp       (rsp_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    // Shadow table and registers
    logic [MAC_BITS-1:0] shadow_key [DEPTH];
    logic [1:0]          shadow_state [DEPTH];
    logic [CFG_W-1:0]    shadow_modulus;
    logic [CFG_W-1:0]    shadow_used;
    bit                  slot_written [DEPTH];
    int                  written_slots [$];
    logic [MAC_BITS-1:0] key_pool [$];

    rsp_t pending_rsp [$];
    int   error_count;
    bit   calm;

    // Directed stimulus row: either a register write or a word, with an
    // optional hand-typed expected result
    typedef struct {
        bit                  is_cfg;
        logic [CFG_IDX_W-1:0] reg_idx;
        logic [CFG_W-1:0]    reg_val;
        logic [1:0]          cmd;
        logic [MAC_BITS-1:0] key;
        logic [POS_W-1:0]    slot;
        bit                  typed;
        rsp_t                want;
    } step_t;

    // Clock
    initial clk = 1'b0;
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Apply one word to the shadow table and return its result
    function automatic rsp_t probe_table(req_t w);
        rsp_t r;
        int   used;
        int   modulus;
        int   pos;
        int   n;
        r       = '0;
        used    = (shadow_used < 1) ? 1 : (shadow_used > DEPTH) ? DEPTH : int'(shadow_used);
        modulus = (shadow_modulus < 1) ? 1 : int'(shadow_modulus);
        if (modulus > used) modulus = used;
        pos = int'(64'(w.mac_key) % 64'(modulus));
        if (w.cmd == CMD_READ)
        begin
            r.status     = RES_READ;
            r.position   = w.slot_index;
            r.slot_state = shadow_state[w.slot_index];
            r.slot_key   = (r.slot_state == SLOT_EMPTY) ? '0 : shadow_key[w.slot_index];
            return r;
        end
        if (w.cmd == CMD_INSERT)
        begin
            for (n = 0; n < used; n++)
            begin
                if (shadow_state[pos] != SLOT_USED)
                begin
                    shadow_key[pos]   = w.mac_key;
                    shadow_state[pos] = SLOT_USED;
                    if (!slot_written[pos])
                    begin
                        slot_written[pos] = 1'b1;
                        written_slots.push_back(pos);
                    end
                    r.status   = RES_INSERTED;
                    r.position = pos[POS_W-1:0];
                    return r;
                end
                pos = (pos + 1) % modulus;
            end
            r.status = RES_FULL;
            return r;
        end
        // delete and search share the probe chain
        for (n = 0; n < used; n++)
        begin
            if (shadow_state[pos] == SLOT_EMPTY) break;
            if (shadow_state[pos] == SLOT_USED && shadow_key[pos] == w.mac_key)
            begin
                if (w.cmd == CMD_DELETE)
                begin
                    shadow_state[pos] = SLOT_DELETED;
                    r.status = RES_DELETED;
                end
                else
                    r.status = RES_FOUND;
                r.position = pos[POS_W-1:0];
                return r;
            end
            pos = (pos + 1) % modulus;
        end
        r.status = RES_NOT_FOUND;
        return r;
    endfunction

    task automatic report(string field, logic [63:0] got, logic [63:0] want);
        error_count++;
        $display("%0t mismatch %s: got %0h want %0h", $time, field, got, want);
    endtask

    // Send one word at the falling edge; random gaps unless calm
    task automatic send_word(req_t w, bit typed, rsp_t want);
        rsp_t r;
        while (!calm && $urandom_range(99) < 38)
        begin
            req_ch.valid <= 1'b0;
            @(negedge clk);
        end
        req_ch.valid <= 1'b1;
        req_ch.data  <= w;
        do @(posedge clk); while (!req_ch.ready);
        r = probe_table(w);
        pending_rsp.push_back(typed ? want : r);
        @(negedge clk);
    endtask

    // Register write once the table has drained
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
        req_ch.valid <= 1'b0;
        wait (pending_rsp.size() == 0);
        repeat (8) @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(negedge clk);
        cfg_we <= 1'b0;
        if (idx == REG_HASH_MODULUS) shadow_modulus = val;
        else shadow_used = val;
    endtask

    // Result receiver stalls at random unless calm
    always @(negedge clk)
        rsp_ch.ready <= calm ? 1'b1 : ($urandom_range(99) >= 38);

    // Result checker
    always @(posedge clk)
    begin
        rsp_t want;
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            if (pending_rsp.size() == 0)
            begin
                error_count++;
                $display("%0t unexpected result word %0h", $time, rsp_ch.data);
            end
            else
            begin
                want = pending_rsp.pop_front();
                if (rsp_ch.data.status != want.status)
                    report("status", rsp_ch.data.status, want.status);
                if (rsp_ch.data.position != want.position)
                    report("position", rsp_ch.data.position, want.position);
                if (rsp_ch.data.slot_key != want.slot_key)
                    report("slot_key", rsp_ch.data.slot_key, want.slot_key);
                if (rsp_ch.data.slot_state != want.slot_state)
                    report("slot_state", rsp_ch.data.slot_state, want.slot_state);
            end
        end
    end

    function automatic rsp_t mk(logic [2:0] s, logic [7:0] p, logic [47:0] k, logic [1:0] st);
        rsp_t r;
        r.status = s; r.position = p; r.slot_key = k; r.slot_state = st;
        return r;
    endfunction

    function automatic step_t op(logic [1:0] c, logic [47:0] k, logic [7:0] s,
                                 bit t = 1'b0, rsp_t w = '0);
        step_t x;
        x = '{default: '0};
        x.cmd = c; x.key = k; x.slot = s; x.typed = t; x.want = w;
        return x;
    endfunction

    function automatic step_t cfg(logic [CFG_IDX_W-1:0] i, logic [CFG_W-1:0] v);
        step_t x;
        x = '{default: '0};
        x.is_cfg = 1'b1; x.reg_idx = i; x.reg_val = v;
        return x;
    endfunction

    function automatic logic [MAC_BITS-1:0] pick_key();
        if (key_pool.size() > 0 && $urandom_range(1))
            return key_pool[$urandom_range(key_pool.size() - 1)];
        case ($urandom_range(3))
            0: return 48'($urandom_range(1023));
            1: return {16'hFFFF, 32'($urandom)};
            default: return {16'($urandom), 32'($urandom)};
        endcase
    endfunction

    // Main sequence
    initial
    begin
        step_t         steps [$];
        req_t          w;
        int            phase;
        int            i;
        int            r;
        logic [CFG_W-1:0] mods [8]  = '{256, 7, 16, 1, 255, 511, 100, 13};
        logic [CFG_W-1:0] useds [8] = '{256, 8, 16, 256, 256, 4, 200, 40};

        error_count    = 0;
        calm           = 1'b0;
        rst_n          = 1'b0;
        cfg_we         = 1'b0;
        cfg_index      = '0;
        cfg_wdata      = '0;
        req_ch.valid   = 1'b0;
        req_ch.data    = '0;
        rsp_ch.ready   = 1'b0;
        shadow_modulus = 256;
        shadow_used    = 256;
        for (i = 0; i < DEPTH; i++)
        begin
            shadow_key[i]   = '0;
            shadow_state[i] = SLOT_EMPTY;
            slot_written[i] = 1'b0;
        end
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed part
        steps.push_back(op(CMD_SEARCH, 48'h0, 8'h00, 1, mk(RES_NOT_FOUND, 0, 0, 0)));
        steps.push_back(op(CMD_INSERT, 48'h0, 8'hFF, 1, mk(RES_INSERTED, 0, 0, 0)));
        steps.push_back(op(CMD_INSERT, 48'hFFFF_FFFF_FFFF, 8'h00, 1,
                           mk(RES_INSERTED, 255, 0, 0)));
        steps.push_back(op(CMD_INSERT, 48'h0, 8'h00, 1, mk(RES_INSERTED, 1, 0, 0)));
        steps.push_back(op(CMD_SEARCH, 48'h0, 8'h00, 1, mk(RES_FOUND, 0, 0, 0)));
        steps.push_back(op(CMD_READ, 48'h0, 8'hFF, 1,
                           mk(RES_READ, 255, 48'hFFFF_FFFF_FFFF, SLOT_USED)));
        steps.push_back(op(CMD_DELETE, 48'h0, 8'h00, 1, mk(RES_DELETED, 0, 0, 0)));
        // tombstone is passed over
        steps.push_back(op(CMD_SEARCH, 48'h0, 8'h00, 1, mk(RES_FOUND, 1, 0, 0)));
        steps.push_back(op(CMD_READ, 48'hFFFF_FFFF_FFFF, 8'h00, 1,
                           mk(RES_READ, 0, 0, SLOT_DELETED)));
        // tombstone is reused by insert
        steps.push_back(op(CMD_INSERT, 48'h100, 8'h00, 1, mk(RES_INSERTED, 0, 0, 0)));
        steps.push_back(op(CMD_DELETE, 48'h0, 8'h00, 1, mk(RES_DELETED, 1, 0, 0)));
        steps.push_back(op(CMD_SEARCH, 48'h0, 8'h00, 1, mk(RES_NOT_FOUND, 0, 0, 0)));
        steps.push_back(op(CMD_DELETE, 48'h12_3456, 8'h00, 1, mk(RES_NOT_FOUND, 0, 0, 0)));
        // zero registers clamp to one slot: table is full
        steps.push_back(cfg(REG_TABLE_USED, 0));
        steps.push_back(cfg(REG_HASH_MODULUS, 0));
        steps.push_back(op(CMD_INSERT, 48'h5, 8'h00, 1, mk(RES_FULL, 0, 0, 0)));
        steps.push_back(op(CMD_SEARCH, 48'h100, 8'h00, 1, mk(RES_FOUND, 0, 0, 0)));
        // oversized table_used clamps to the table depth
        steps.push_back(cfg(REG_TABLE_USED, 511));
        steps.push_back(cfg(REG_HASH_MODULUS, 3));
        steps.push_back(op(CMD_INSERT, 48'h7, 8'h00));
        steps.push_back(op(CMD_INSERT, 48'h7, 8'h00));
        steps.push_back(op(CMD_SEARCH, 48'h7, 8'h00));
        steps.push_back(op(CMD_READ, 48'h0, 8'h02));

        @(negedge clk);
        foreach (steps[k])
        begin
            if (steps[k].is_cfg)
                write_reg(steps[k].reg_idx, steps[k].reg_val);
            else
            begin
                w.cmd        = steps[k].cmd;
                w.mac_key    = steps[k].key;
                w.slot_index = steps[k].slot;
                send_word(w, steps[k].typed, steps[k].want);
            end
        end

        // Random phases, one register setting each
        for (phase = 0; phase < 8; phase++)
        begin
            write_reg(REG_HASH_MODULUS, mods[phase]);
            write_reg(REG_TABLE_USED, useds[phase]);
            calm = (phase == 2);
            for (i = 0; i < 190; i++)
            begin
                r = $urandom_range(99);
                w.mac_key    = pick_key();
                w.slot_index = 8'($urandom);
                if (r < 35 || (r >= 85 && written_slots.size() == 0))
                begin
                    w.cmd = CMD_INSERT;
                    key_pool.push_back(w.mac_key);
                    if (key_pool.size() > 48) void'(key_pool.pop_front());
                end
                else if (r < 55)
                    w.cmd = CMD_DELETE;
                else if (r < 85)
                    w.cmd = CMD_SEARCH;
                else
                begin
                    // only slots that have held a key are read
                    w.cmd        = CMD_READ;
                    w.slot_index = 8'(written_slots[$urandom_range(written_slots.size() - 1)]);
                end
                send_word(w, 1'b0, '0);
            end
            calm = 1'b0;
        end

        req_ch.valid <= 1'b0;
        wait (pending_rsp.size() == 0);
        repeat (20) @(posedge clk);
        if (error_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    // Watchdog
    initial
    begin
        #100_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule

// File: filelist.f
+incdir+hw/rtl
hw/rtl/lpht_pkg.sv
hw/rtl/lpht_chan_if.sv
hw/rtl/lpht_front.sv
hw/rtl/lpht_queue.sv
hw/rtl/lpht_back.sv
hw/rtl/linear_probe_hash_table_unit.sv
hw/rtl/lpht_checker.sv
tb/tb.sv
